[rtl/strmq_pkg.sv]
// Package for the sparse-table range-maximum block.
// Holds sizes, operation codes, the modulus and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package strmq_pkg;
	localparam int DEPTH = 1024;
	localparam int LEVELS = 11;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int LVL_W = 4;
	localparam int ANS_W = 30;
	localparam int TAB_AW = LVL_W + IDX_W;
	localparam logic [ANS_W-1:0] MOD_PRIME = 30'd1000000007;
	localparam logic [31:0] MOD_X2 = 32'd2000000014;
	localparam logic [31:0] MOD_X3 = 32'd3000000021;
	localparam logic [31:0] MOD_X4 = 32'd4000000028;
	localparam logic [30:0] BAR_MU = 31'((64'd1 << 60) / 64'd1000000007);
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic load;
		logic clear;
		logic app_start;
		logic app_rd;
		logic app_wr;
		logic qry_rd;
		logic qry_max;
		logic pre;
		logic mul;
		logic bar_q;
		logic bar_r;
		logic red_sub;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic app_more;
		logic qry_bad;
	} sts_t;
endpackage

[rtl/strmq_ctrl.sv]
// Controller state machine for the sparse-table range-maximum block.
// Depends on strmq_pkg; drives the datapath through ctl_t, reads sts_t.
`timescale 1ns / 1ps
module strmq_ctrl import strmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [1:0] op,
	input  logic       out_busy,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       idle
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_ARD = 4'd2;
	localparam logic [3:0] S_AWAIT = 4'd3;
	localparam logic [3:0] S_AWR = 4'd4;
	localparam logic [3:0] S_QRD = 4'd5;
	localparam logic [3:0] S_QWAIT = 4'd6;
	localparam logic [3:0] S_QMAX = 4'd7;
	localparam logic [3:0] S_PRE = 4'd8;
	localparam logic [3:0] S_MUL = 4'd9;
	localparam logic [3:0] S_BARQ = 4'd10;
	localparam logic [3:0] S_BARR = 4'd11;
	localparam logic [3:0] S_SUB = 4'd12;
	localparam logic [3:0] S_OUT = 4'd13;

	logic [3:0] state_q, state_d;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_CLEAR;
		end else begin
			state_q <= state_d;
			if (in_fire) op_q <= op;
		end
	end

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.load = in_fire;
		case (state_q)
			S_IDLE: if (in_fire) state_d = S_DEC;
			S_DEC: begin
				case (op_q)
					OP_CLEAR: begin
						ctl.clear = 1'b1;
						state_d = S_IDLE;
					end
					OP_APPEND: begin
						if (sts.full) state_d = S_IDLE;
						else begin
							ctl.app_start = 1'b1;
							state_d = S_ARD;
						end
					end
					OP_QUERY: state_d = sts.qry_bad ? S_OUT : S_QRD;
					default: state_d = S_IDLE;
				endcase
			end
			S_ARD: begin
				ctl.app_rd = 1'b1;
				state_d = S_AWAIT;
			end
			S_AWAIT: state_d = S_AWR;
			S_AWR: begin
				ctl.app_wr = 1'b1;
				state_d = sts.app_more ? S_ARD : S_IDLE;
			end
			S_QRD: begin
				ctl.qry_rd = 1'b1;
				state_d = S_QWAIT;
			end
			S_QWAIT: state_d = S_QMAX;
			S_QMAX: begin
				ctl.qry_max = 1'b1;
				state_d = S_PRE;
			end
			S_PRE: begin
				ctl.pre = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_BARQ;
			end
			S_BARQ: begin
				ctl.bar_q = 1'b1;
				state_d = S_BARR;
			end
			S_BARR: begin
				ctl.bar_r = 1'b1;
				state_d = S_SUB;
			end
			S_SUB: begin
				ctl.red_sub = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					ctl.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

[rtl/strmq_datapath.sv]
// Datapath for the sparse-table range-maximum block: table memory, power store,
// count, multiplier and a Barrett modular reduction. Depends on strmq_pkg.
`timescale 1ns / 1ps
module strmq_datapath import strmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [31:0]      in_value,
	input  logic [IDX_W-1:0] in_first,
	input  logic [IDX_W-1:0] in_last,
	output sts_t             sts,
	output logic [ANS_W-1:0] res_answer,
	output logic             res_status
);
	logic [VALUE_WIDTH-1:0] tab_mem [DEPTH*LEVELS];
	logic [ANS_W-1:0] pow_mem [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [IDX_W-1:0] first_q, last_q;
	logic [LVL_W-1:0] lvl_q;
	logic [VALUE_WIDTH-1:0] rda_q, rdb_q, max_q;
	logic [ANS_W-1:0] pow_rd_q, pow_last_q;
	logic [ANS_W-1:0] maxr_q;
	logic [59:0] prod_q;
	logic [61:0] q2_q;
	logic [31:0] r_q;
	logic [ANS_W-1:0] ans_q;
	logic bad_q;

	logic [CNT_W-1:0] pos;
	logic [CNT_W:0] span;
	logic [CNT_W-1:0] start;
	logic [IDX_W-1:0] len_m1;
	logic [CNT_W-1:0] len;
	logic [LVL_W-1:0] qlvl;
	logic [CNT_W-1:0] qoff;
	logic [ANS_W:0] dbl;
	logic [ANS_W-1:0] pow_new;
	logic [31:0] max_wide;
	logic [31:0] max_sub;

	assign pos = count_q;
	assign span = (CNT_W+1)'(1) << lvl_q;
	assign start = CNT_W'(({1'b0, pos} + (CNT_W+1)'(1)) - span);
	assign len_m1 = last_q - first_q;
	assign len = CNT_W'(len_m1) + CNT_W'(1);
	always_comb begin
		qlvl = '0;
		for (int i = 0; i < CNT_W; i++) if (len[i]) qlvl = LVL_W'(i);
		if (qlvl > LVL_W'(LEVELS - 1)) qlvl = LVL_W'(LEVELS - 1);
	end
	assign qoff = CNT_W'({1'b0, last_q} + CNT_W'(1) - (CNT_W'(1) << qlvl));
	assign dbl = {pow_last_q, 1'b0};
	assign pow_new = (count_q == '0) ? ANS_W'(1) :
		((dbl >= {1'b0, MOD_PRIME}) ? ANS_W'(dbl - {1'b0, MOD_PRIME}) : ANS_W'(dbl));

	always_comb begin
		max_wide = 32'(max_q);
		if (max_wide >= MOD_X4) max_sub = MOD_X4;
		else if (max_wide >= MOD_X3) max_sub = MOD_X3;
		else if (max_wide >= MOD_X2) max_sub = MOD_X2;
		else if (max_wide >= 32'(MOD_PRIME)) max_sub = 32'(MOD_PRIME);
		else max_sub = '0;
	end

	assign sts.full = (count_q == CNT_W'(DEPTH));
	assign sts.app_more = (lvl_q < LVL_W'(LEVELS - 1)) &&
		({1'b0, pos} + (CNT_W+1)'(1) >= (span << 1));
	assign sts.qry_bad = (first_q > last_q) || ({1'b0, last_q} >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bad_q <= 1'b0;
		end else begin
			if (ctl.clear) count_q <= '0;
			if (ctl.app_wr && !sts.app_more) count_q <= count_q + CNT_W'(1);
			if (ctl.load) bad_q <= 1'b0;
			if (ctl.qry_rd || ctl.mul) bad_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= in_value[VALUE_WIDTH-1:0];
			first_q <= in_first;
			last_q <= in_last;
		end
		if (ctl.app_start) begin
			tab_mem[TAB_AW'(pos)] <= val_q;
			pow_mem[IDX_W'(pos)] <= pow_new;
			pow_last_q <= pow_new;
			lvl_q <= LVL_W'(1);
		end
		if (ctl.app_rd) begin
			rda_q <= tab_mem[TAB_AW'((lvl_q - LVL_W'(1)) * DEPTH) + TAB_AW'(start)];
			rdb_q <= tab_mem[TAB_AW'((lvl_q - LVL_W'(1)) * DEPTH) + TAB_AW'(start)
				+ TAB_AW'(span >> 1)];
		end
		if (ctl.app_wr) begin
			if ({1'b0, pos} + (CNT_W+1)'(1) >= span)
				tab_mem[TAB_AW'(lvl_q * DEPTH) + TAB_AW'(start)] <=
					(rda_q > rdb_q) ? rda_q : rdb_q;
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (ctl.qry_rd) begin
			rda_q <= tab_mem[TAB_AW'(qlvl * DEPTH) + TAB_AW'(first_q)];
			rdb_q <= tab_mem[TAB_AW'(qlvl * DEPTH) + TAB_AW'(qoff)];
			pow_rd_q <= pow_mem[len_m1];
		end
		if (ctl.qry_max) max_q <= (rda_q > rdb_q) ? rda_q : rdb_q;
		if (ctl.pre) maxr_q <= ANS_W'(max_wide - max_sub);
		if (ctl.mul) prod_q <= 60'(maxr_q) * 60'(pow_rd_q);
		if (ctl.bar_q) q2_q <= 62'(prod_q[59:29]) * 62'(BAR_MU);
		if (ctl.bar_r) r_q <= 32'(prod_q - 60'(q2_q[61:31]) * 60'(MOD_PRIME));
		if (ctl.red_sub) begin
			if (r_q >= MOD_X2) ans_q <= ANS_W'(r_q - MOD_X2);
			else if (r_q >= 32'(MOD_PRIME)) ans_q <= ANS_W'(r_q - 32'(MOD_PRIME));
			else ans_q <= ANS_W'(r_q);
		end
	end

	assign res_answer = sts.qry_bad ? '0 : ans_q;
	assign res_status = sts.qry_bad | bad_q;
endmodule

[rtl/sparse_table_range_max_query.sv]
// Top level of the sparse-table range-maximum block: stream ports, output register.
// Instantiates strmq_ctrl and strmq_datapath; depends on strmq_pkg. One transaction at a time.
// Per operation: a clear or a dropped append is decoded and done; an append runs at least one level
// pass, and a query does two reads, maximum, multiply, four-step reduction; a failed query goes
// straight to output. A stalled receiver holds the next result in its output state.
// Reset clears count and control; tables stay undefined.
`timescale 1ns / 1ps
module sparse_table_range_max_query import strmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // value[31:0], first[41:32], last[51:42]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // answer[29:0]
	output logic        m_tuser   // status[0]
);
	ctl_t ctl;
	sts_t sts;
	logic idle, in_fire;
	logic [ANS_W-1:0] res_answer;
	logic res_status;
	logic [30:0] out_q;
	logic out_valid_q;

	assign s_tready = idle;
	assign in_fire = s_tvalid & s_tready;

	strmq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .op(s_tuser),
		.out_busy(out_valid_q & ~m_tready), .sts(sts), .ctl(ctl), .idle(idle)
	);

	strmq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .in_value(s_tdata[31:0]),
		.in_first(s_tdata[41:32]), .in_last(s_tdata[51:42]), .sts(sts),
		.res_answer(res_answer), .res_status(res_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) out_q <= {res_status, res_answer};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_q[29:0]};
	assign m_tuser = out_q[30];
endmodule

[rtl/strmq_checker.sv]
// Port-level checker for the sparse-table range-maximum block.
// Bound to sparse_table_range_max_query; no other dependencies.
`timescale 1ns / 1ps
module strmq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second transaction while busy");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[29:0] == 30'd0)
		else $error("failed query carries nonzero answer");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("pad bits set");
endmodule

bind sparse_table_range_max_query strmq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
